### src/ccx_pkg.sv
// Package: shared types and constants for the ChaCha20 byte-stream cipher.
package ccx_pkg;

   localparam int KeyWidth = 64;
   localparam int DataWidth = 8;
   localparam int CsrIndexWidth = 3;
   localparam int DoubleRoundsDefault = 10;
   localparam int TagSpanDefault = 16;

   localparam logic [CsrIndexWidth-1:0] CsrKey0 = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CsrKey1 = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CsrKey2 = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CsrKey3 = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CsrNonce = 3'd4;

   localparam logic [31:0] Sigma0 = 32'h61707865;
   localparam logic [31:0] Sigma1 = 32'h3320646e;
   localparam logic [31:0] Sigma2 = 32'h79622d32;
   localparam logic [31:0] Sigma3 = 32'h6b206574;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_ADD,
      ST_OUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic take_word;    // latch the input word
      logic load_block;   // load initial state for a new block
      logic do_round;     // one column or diagonal half round
      logic add_block;    // feed-forward add, bump counter
      logic emit;         // apply keystream byte, load output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_block;   // the held word starts a new block
      logic rounds_done;
   } status_type;

   function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
      rotl = (v << n) | (v >> (32 - n));
   endfunction

   function automatic logic [127:0] quarter(input logic [127:0] abcd);
      logic [31:0] a, b, c, d;
      begin
         a = abcd[127:96];
         b = abcd[95:64];
         c = abcd[63:32];
         d = abcd[31:0];
         a = a + b; d = rotl(d ^ a, 16);
         c = c + d; b = rotl(b ^ c, 12);
         a = a + b; d = rotl(d ^ a, 8);
         c = c + d; b = rotl(b ^ c, 7);
         quarter = {a, b, c, d};
      end
   endfunction

endpackage

### src/ccx_ctrl.sv
// Controller: sequences block generation and per-word output.
module ccx_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   output logic rsp_valid,
   input  logic rsp_stall,
   input  ccx_pkg::status_type status,
   output ccx_pkg::cmd_type cmd
);
   import ccx_pkg::*;

   state_type state_ff, state_in;
   logic out_valid_ff, out_valid_in;
   logic accept;

   // output register frees when taken, so a new word may start meanwhile
   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_ROUND;
         ST_ROUND: begin
            if (!status.need_block || status.rounds_done) begin
               state_in = status.need_block ? ST_ADD : ST_OUT;
            end
         end
         ST_ADD: state_in = ST_OUT;
         ST_OUT: if (!out_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.take_word = accept;
      cmd.load_block = (state_ff == ST_IDLE) && accept;
      cmd.do_round = (state_ff == ST_ROUND) && status.need_block && !status.rounds_done;
      cmd.add_block = (state_ff == ST_ADD);
      cmd.emit = (state_ff == ST_OUT) && (!out_valid_ff || !rsp_stall);
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_valid_ff && !rsp_stall) out_valid_in = 1'b0;
      if (cmd.emit) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end
endmodule

### src/ccx_datapath.sv
// Datapath: key registers, round unit, keystream block and tag.
module ccx_datapath #(
   parameter int DOUBLE_ROUNDS = ccx_pkg::DoubleRoundsDefault,
   parameter int TAG_SPAN = ccx_pkg::TagSpanDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic [ccx_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [ccx_pkg::KeyWidth-1:0] csr_data,
   input  logic [ccx_pkg::DataWidth-1:0] req_data_byte,
   input  logic req_mode,
   input  logic req_first,
   input  logic req_last,
   output logic [ccx_pkg::DataWidth-1:0] rsp_out_byte,
   output logic [ccx_pkg::DataWidth-1:0] rsp_tag,
   output logic rsp_end_of_message,
   input  ccx_pkg::cmd_type cmd,
   output ccx_pkg::status_type status
);
   import ccx_pkg::*;

   localparam int HalfRounds = 2 * DOUBLE_ROUNDS;
   localparam int RoundWidth = $clog2(HalfRounds + 1);
   localparam int SeenWidth = $clog2(TAG_SPAN + 1);

   logic [63:0] key_ff [4];
   logic [63:0] nonce_ff;
   logic [31:0] work_ff [16];
   logic [31:0] ks_ff [16];
   logic [63:0] counter_ff, counter_in;
   logic [5:0] pos_ff, pos_in;
   logic [7:0] tag_ff, tag_in;
   logic [SeenWidth-1:0] seen_ff, seen_in;
   logic [RoundWidth-1:0] round_ff;
   logic [7:0] data_ff;
   logic mode_ff, last_ff;
   logic [7:0] out_byte_ff, tag_out_ff;
   logic eom_ff;
   logic [31:0] init [16];
   logic [31:0] rnd [16];
   logic [7:0] ks_byte, result, cipher;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
         nonce_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CsrKey0: key_ff[0] <= csr_data;
            CsrKey1: key_ff[1] <= csr_data;
            CsrKey2: key_ff[2] <= csr_data;
            CsrKey3: key_ff[3] <= csr_data;
            CsrNonce: nonce_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // first clears stream state before the word is processed
   always_comb begin
      counter_in = counter_ff;
      pos_in = pos_ff;
      tag_in = tag_ff;
      seen_in = seen_ff;
      if (cmd.take_word && req_first) begin
         counter_in = '0;
         pos_in = '0;
         tag_in = '0;
         seen_in = '0;
      end
      if (cmd.add_block) counter_in = counter_ff + 64'd1;
      if (cmd.emit) begin
         pos_in = pos_ff + 6'd1;
         if (seen_ff < SeenWidth'(TAG_SPAN)) begin
            tag_in = tag_ff ^ cipher;
            seen_in = seen_ff + SeenWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
         pos_ff <= '0;
         tag_ff <= '0;
         seen_ff <= '0;
      end else begin
         counter_ff <= counter_in;
         pos_ff <= pos_in;
         tag_ff <= tag_in;
         seen_ff <= seen_in;
      end
   end

   always_comb begin
      init[0] = Sigma0; init[1] = Sigma1; init[2] = Sigma2; init[3] = Sigma3;
      for (int i = 0; i < 4; i++) begin
         init[4 + 2 * i] = key_ff[i][31:0];
         init[5 + 2 * i] = key_ff[i][63:32];
      end
      init[12] = counter_in[31:0];
      init[13] = counter_in[63:32];
      init[14] = nonce_ff[31:0];
      init[15] = nonce_ff[63:32];
   end

   // even steps: columns, odd steps: diagonals
   always_comb begin
      logic [127:0] q;
      for (int i = 0; i < 16; i++) rnd[i] = work_ff[i];
      for (int j = 0; j < 4; j++) begin
         if (!round_ff[0]) begin
            q = quarter({work_ff[j], work_ff[4 + j], work_ff[8 + j], work_ff[12 + j]});
            rnd[j] = q[127:96]; rnd[4 + j] = q[95:64];
            rnd[8 + j] = q[63:32]; rnd[12 + j] = q[31:0];
         end else begin
            q = quarter({work_ff[j], work_ff[4 + (j + 1) % 4],
                         work_ff[8 + (j + 2) % 4], work_ff[12 + (j + 3) % 4]});
            rnd[j] = q[127:96]; rnd[4 + (j + 1) % 4] = q[95:64];
            rnd[8 + (j + 2) % 4] = q[63:32]; rnd[12 + (j + 3) % 4] = q[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_block) begin
         for (int i = 0; i < 16; i++) work_ff[i] <= init[i];
         round_ff <= '0;
      end else if (cmd.do_round) begin
         for (int i = 0; i < 16; i++) work_ff[i] <= rnd[i];
         round_ff <= round_ff + RoundWidth'(1);
      end
      // counter_ff still holds this block's counter here
      if (cmd.add_block) begin
         for (int i = 0; i < 12; i++) ks_ff[i] <= work_ff[i] + init[i];
         ks_ff[12] <= work_ff[12] + counter_ff[31:0];
         ks_ff[13] <= work_ff[13] + counter_ff[63:32];
         ks_ff[14] <= work_ff[14] + init[14];
         ks_ff[15] <= work_ff[15] + init[15];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_word) begin
         data_ff <= req_data_byte;
         mode_ff <= req_mode;
         last_ff <= req_last;
      end
   end

   assign status.need_block = (pos_ff == 6'd0);
   assign status.rounds_done = (round_ff == RoundWidth'(HalfRounds));

   assign ks_byte = ks_ff[pos_ff[5:2]][8 * pos_ff[1:0] +: 8];
   assign result = data_ff ^ ks_byte;
   assign cipher = mode_ff ? data_ff : result;

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_byte_ff <= result;
         tag_out_ff <= tag_in;
         eom_ff <= last_ff;
      end
   end

   assign rsp_out_byte = out_byte_ff;
   assign rsp_tag = tag_out_ff;
   assign rsp_end_of_message = eom_ff;
endmodule

### src/chacha20_stream_xor_tag.sv
// Each accepted word passes through ST_ROUND and ST_OUT; the word that opens
// a 64-byte block first runs 2*DOUBLE_ROUNDS half rounds (one half round per
// cycle) and ST_ADD. A new word is taken only in ST_IDLE, once the last is
// loaded; a stalled result register holds the next word in its output state.
// Synchronous reset clears key, nonce, counter, position, tag and handshakes.
module chacha20_stream_xor_tag #(
   parameter int DOUBLE_ROUNDS = ccx_pkg::DoubleRoundsDefault,
   parameter int TAG_SPAN = ccx_pkg::TagSpanDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic [ccx_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [ccx_pkg::KeyWidth-1:0] csr_data,
   input  logic req_valid,
   output logic req_stall,
   input  logic [ccx_pkg::DataWidth-1:0] req_data_byte,
   input  logic req_mode,
   input  logic req_first,
   input  logic req_last,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [ccx_pkg::DataWidth-1:0] rsp_out_byte,
   output logic [ccx_pkg::DataWidth-1:0] rsp_tag,
   output logic rsp_end_of_message
);
   import ccx_pkg::*;

   cmd_type cmd;
   status_type status;

   ccx_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .status(status), .cmd(cmd)
   );

   ccx_datapath #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS), .TAG_SPAN(TAG_SPAN)) u_dp (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_data_byte(req_data_byte), .req_mode(req_mode),
      .req_first(req_first), .req_last(req_last),
      .rsp_out_byte(rsp_out_byte), .rsp_tag(rsp_tag),
      .rsp_end_of_message(rsp_end_of_message),
      .cmd(cmd), .status(status)
   );
endmodule

### src/ccx_checker.sv
// Port-level checker for the ChaCha20 byte-stream cipher, bound to the top.
module ccx_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic [7:0] rsp_tag
);
   // a word is taken, so the input stalls next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall) else $error("no stall after accept");

   // no response can appear in the cycle after an idle, empty block
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_stall && !rsp_valid |=> !rsp_valid) else $error("response without word");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_tag))
      else $error("stalled response changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall) else $error("not idle after reset");
endmodule

bind chacha20_stream_xor_tag ccx_checker u_ccx_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_out_byte(rsp_out_byte), .rsp_tag(rsp_tag)
);

### bench/chacha_checker.sv
// Watches the cipher channels, predicts each result word and compares it.
module chacha_checker #(
   parameter int DOUBLE_ROUNDS = ccx_pkg::DoubleRoundsDefault,
   parameter int TAG_SPAN = ccx_pkg::TagSpanDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic [ccx_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [ccx_pkg::KeyWidth-1:0] csr_data,
   input  logic req_valid,
   input  logic req_stall,
   input  logic [7:0] req_data_byte,
   input  logic req_mode,
   input  logic req_first,
   input  logic req_last,
   input  logic rsp_valid,
   input  logic rsp_stall,
   input  logic [7:0] rsp_out_byte,
   input  logic [7:0] rsp_tag,
   input  logic rsp_end_of_message,
   output int errors,
   output int pending,
   output int results_seen
);
   import ccx_pkg::*;

   typedef struct {
      logic [7:0] out_byte;
      logic [7:0] tag;
      logic       eom;
   } cipher_word_type;

   cipher_word_type expected_words[$];

   logic [63:0] key_reg[4];
   logic [63:0] nonce_reg;
   logic [31:0] ks_words[16];
   logic [5:0]  ks_pos;
   logic [63:0] blk_count;
   logic [7:0]  tag_acc;
   int          tag_count;

   function automatic logic [31:0] rol32(logic [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   task automatic mix(inout logic [31:0] a, inout logic [31:0] b,
                      inout logic [31:0] c, inout logic [31:0] d);
      a = a + b; d = rol32(d ^ a, 16);
      c = c + d; b = rol32(b ^ c, 12);
      a = a + b; d = rol32(d ^ a, 8);
      c = c + d; b = rol32(b ^ c, 7);
   endtask

   task automatic refill_keystream();
      logic [31:0] seed[16];
      logic [31:0] w[16];
      seed[0] = Sigma0; seed[1] = Sigma1; seed[2] = Sigma2; seed[3] = Sigma3;
      for (int i = 0; i < 4; i++) begin
         seed[4 + 2 * i] = key_reg[i][31:0];
         seed[5 + 2 * i] = key_reg[i][63:32];
      end
      seed[12] = blk_count[31:0];
      seed[13] = blk_count[63:32];
      seed[14] = nonce_reg[31:0];
      seed[15] = nonce_reg[63:32];
      w = seed;
      for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
         mix(w[0], w[4], w[8], w[12]);
         mix(w[1], w[5], w[9], w[13]);
         mix(w[2], w[6], w[10], w[14]);
         mix(w[3], w[7], w[11], w[15]);
         mix(w[0], w[5], w[10], w[15]);
         mix(w[1], w[6], w[11], w[12]);
         mix(w[2], w[7], w[8], w[13]);
         mix(w[3], w[4], w[9], w[14]);
      end
      for (int i = 0; i < 16; i++) ks_words[i] = w[i] + seed[i];
      blk_count = blk_count + 64'd1;
   endtask

   task automatic predict_cipher(logic [7:0] data, logic mode, logic first, logic last);
      cipher_word_type e;
      logic [7:0] ks;
      if (first) begin
         blk_count = '0;
         ks_pos = '0;
         tag_acc = '0;
         tag_count = 0;
      end
      if (ks_pos == 6'd0) refill_keystream();
      ks = 8'(ks_words[ks_pos[5:2]] >> (8 * ks_pos[1:0]));
      e.out_byte = data ^ ks;
      // the tag always follows the ciphertext side
      if (tag_count < TAG_SPAN) begin
         tag_acc = tag_acc ^ (mode ? data : e.out_byte);
         tag_count++;
      end
      ks_pos = ks_pos + 6'd1;
      e.tag = tag_acc;
      e.eom = last;
      expected_words.push_back(e);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_reg[i] = '0;
         nonce_reg = '0;
         ks_pos = '0;
         blk_count = '0;
         tag_acc = '0;
         tag_count = 0;
         expected_words.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CsrKey0: key_reg[0] = csr_data;
               CsrKey1: key_reg[1] = csr_data;
               CsrKey2: key_reg[2] = csr_data;
               CsrKey3: key_reg[3] = csr_data;
               CsrNonce: nonce_reg = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            predict_cipher(req_data_byte, req_mode, req_first, req_last);
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_words.size() == 0) begin
               errors++;
               $display("%0t: unexpected word out=%h tag=%h eom=%b", $time,
                        rsp_out_byte, rsp_tag, rsp_end_of_message);
            end else begin
               cipher_word_type e;
               e = expected_words.pop_front();
               if (e.out_byte !== rsp_out_byte || e.tag !== rsp_tag ||
                   e.eom !== rsp_end_of_message) begin
                  errors++;
                  $display("%0t: mismatch expected out=%h tag=%h eom=%b actual out=%h tag=%h eom=%b",
                           $time, e.out_byte, e.tag, e.eom,
                           rsp_out_byte, rsp_tag, rsp_end_of_message);
               end
            end
         end
      end
      pending <= expected_words.size();
   end

   initial begin
      errors = 0;
      pending = 0;
      results_seen = 0;
   end
endmodule

### bench/tb_top.sv
// Stimulus, idling, watchdog and verdict for the ChaCha20 byte-stream cipher.
module tb_top;
   import ccx_pkg::*;

   localparam int DRAIN_CYCLES = 2 * DoubleRoundsDefault + 12;
   localparam int IDLE_LIMIT = 5000;

   logic clock, reset;
   logic csr_write;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [KeyWidth-1:0] csr_data;
   logic req_valid, req_stall, req_mode, req_first, req_last;
   logic [DataWidth-1:0] req_data_byte;
   logic rsp_valid, rsp_stall, rsp_end_of_message;
   logic [DataWidth-1:0] rsp_out_byte, rsp_tag;
   int errors, pending, results_seen;
   int messages, phases, idle_run;
   bit calm, held_once;

   chacha20_stream_xor_tag u_top (.*);

   chacha_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_word(logic [7:0] data, logic mode, logic first, logic last);
      int gap;
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_mode <= mode;
      req_first <= first;
      req_last <= last;
      do @(posedge clock); while (req_stall);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drain all results, then let the round unit settle
   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_keys(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                            logic [63:0] k3, logic [63:0] nv);
      logic [63:0] vals[5];
      logic [CsrIndexWidth-1:0] idx[5];
      vals = '{k0, k1, k2, k3, nv};
      idx = '{CsrKey0, CsrKey1, CsrKey2, CsrKey3, CsrNonce};
      for (int i = 0; i < 5; i++) begin
         csr_write <= 1'b1;
         csr_index <= idx[i];
         csr_data <= vals[i];
         @(posedge clock);
      end
      csr_write <= 1'b0;
      phases++;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_message(int len, bit broken);
      logic mode;
      mode = 1'($urandom_range(0, 1));
      for (int i = 0; i < len; i++) begin
         if (broken)
            send_word(8'($urandom), 1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0,
                      $urandom_range(0, 9) == 0);
         else
            send_word(8'($urandom), mode, i == 0, i == len - 1);
      end
      messages++;
   endtask

   task automatic random_traffic(int budget);
      int len, r;
      while (budget > 0) begin
         r = $urandom_range(0, 99);
         if (r < 70) len = $urandom_range(1, 40);
         else if (r < 90) len = $urandom_range(41, 140);
         else len = $urandom_range(141, 200);
         send_message(len, $urandom_range(0, 9) == 0);
         budget -= len;
      end
   endtask

   // random receiver stalls, plus one long hold while the sender keeps offering words
   initial begin
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         int n;
         if (!held_once && results_seen > 300) begin
            held_once = 1;
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
         end
         n = pick_gap();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat (calm ? 20 : $urandom_range(1, 6)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
         idle_run <= 0;
      else
         idle_run <= idle_run + 1;
      if (idle_run >= IDLE_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      reset = 1; csr_write = 0; csr_index = '0; csr_data = '0;
      req_valid = 0; req_data_byte = '0; req_mode = 0; req_first = 0; req_last = 0;
      idle_run = 0; messages = 0; phases = 0; calm = 0; held_once = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // all-zero key; stream starts without a first flag
      send_word(8'h00, 1'b0, 1'b0, 1'b0);
      send_word(8'hFF, 1'b0, 1'b0, 1'b0);
      send_word(8'h5A, 1'b1, 1'b0, 1'b1);
      // keystream continues after last without first
      send_word(8'hA5, 1'b1, 1'b0, 1'b0);
      send_word(8'h01, 1'b0, 1'b0, 1'b1);
      // one-word message, a message shorter than the tag span, then one longer than it
      send_word(8'hFF, 1'b1, 1'b1, 1'b1);
      for (int i = 0; i < 5; i++) send_word(8'(8'h80 >> i), 1'b1, i == 0, i == 4);
      for (int i = 0; i < 18; i++) send_word(i[0] ? 8'hFF : 8'h00, 1'b0, i == 0, i == 17);
      quiesce();

      load_keys('1, '1, '1, '1, '1);
      calm = 1;
      random_traffic(150);
      calm = 0;
      quiesce();

      load_keys(rand64(), rand64(), rand64(), rand64(), rand64());
      random_traffic(250);
      quiesce();

      load_keys(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, '0, '1,
                64'h0000_0001_FFFF_FFFF);
      random_traffic(200);
      quiesce();

      for (int p = 0; p < 3; p++) begin
         load_keys(rand64(), rand64(), rand64(), rand64(), rand64());
         random_traffic(170);
         quiesce();
      end

      $display("covered %0d messages, %0d words, %0d key/nonce settings",
               messages, results_seen, phases);
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
